// ===== rtl/tfidf_pkg.sv =====
// tfidf_pkg: shared types, field widths, codes and the Q16 natural-log table
// for the TF-IDF scorer. No dependencies.
`default_nettype none

package tfidf_pkg;

  // Field widths
  localparam int KIND_W     = 2;
  localparam int WORD_W     = 7;
  localparam int CNT_W      = 16;
  localparam int SCORE_W    = 34;
  localparam int DOCS_W     = 5;
  localparam int NWORDS_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Log table geometry: ln(k) in Q16 for k = 0..64 fits in 19 bits
  localparam int LN_W       = 19;
  localparam int LN_IDX_W   = 7;
  localparam int LN_MAX_IDX = 64;
  localparam int WORD_SPAN  = 128;

  // Arithmetic widths: product of count and log difference, padded divider word
  localparam int PROD_W = CNT_W + LN_W;
  localparam int DIV_W  = PROD_W + (PROD_W % 2);

  // Word kinds
  localparam logic [KIND_W-1:0] KIND_TALLY = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCORE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_DOCS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_WORDS = 2'd1;

  localparam logic [DOCS_W-1:0]   NUM_DOCS_RST  = 5'd1;
  localparam logic [NWORDS_W-1:0] NUM_WORDS_RST = 8'd128;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [WORD_W-1:0] word_index;
    logic [CNT_W-1:0]  count;
  } tfidf_in_t;

  typedef struct packed {
    logic [SCORE_W-1:0] score;
    logic               idf_undefined;
  } tfidf_out_t;

  function automatic logic [LN_W-1:0] ln_q16(input logic [LN_IDX_W-1:0] k);
    logic [LN_W-1:0] v;
    unique case (k)
      7'd0:  v = 19'd0;       7'd1:  v = 19'd0;
      7'd2:  v = 19'd45426;   7'd3:  v = 19'd71999;
      7'd4:  v = 19'd90852;   7'd5:  v = 19'd105476;
      7'd6:  v = 19'd117425;  7'd7:  v = 19'd127527;
      7'd8:  v = 19'd136278;  7'd9:  v = 19'd143997;
      7'd10: v = 19'd150902;  7'd11: v = 19'd157148;
      7'd12: v = 19'd162851;  7'd13: v = 19'd168097;
      7'd14: v = 19'd172953;  7'd15: v = 19'd177475;
      7'd16: v = 19'd181704;  7'd17: v = 19'd185677;
      7'd18: v = 19'd189423;  7'd19: v = 19'd192967;
      7'd20: v = 19'd196328;  7'd21: v = 19'd199526;
      7'd22: v = 19'd202575;  7'd23: v = 19'd205488;
      7'd24: v = 19'd208277;  7'd25: v = 19'd210952;
      7'd26: v = 19'd213523;  7'd27: v = 19'd215996;
      7'd28: v = 19'd218379;  7'd29: v = 19'd220679;
      7'd30: v = 19'd222901;  7'd31: v = 19'd225050;
      7'd32: v = 19'd227130;  7'd33: v = 19'd229147;
      7'd34: v = 19'd231104;  7'd35: v = 19'd233003;
      7'd36: v = 19'd234849;  7'd37: v = 19'd236645;
      7'd38: v = 19'd238393;  7'd39: v = 19'd240095;
      7'd40: v = 19'd241754;  7'd41: v = 19'd243373;
      7'd42: v = 19'd244952;  7'd43: v = 19'd246494;
      7'd44: v = 19'd248001;  7'd45: v = 19'd249473;
      7'd46: v = 19'd250914;  7'd47: v = 19'd252323;
      7'd48: v = 19'd253703;  7'd49: v = 19'd255054;
      7'd50: v = 19'd256378;  7'd51: v = 19'd257676;
      7'd52: v = 19'd258949;  7'd53: v = 19'd260197;
      7'd54: v = 19'd261422;  7'd55: v = 19'd262625;
      7'd56: v = 19'd263805;  7'd57: v = 19'd264965;
      7'd58: v = 19'd266105;  7'd59: v = 19'd267225;
      7'd60: v = 19'd268327;  7'd61: v = 19'd269410;
      7'd62: v = 19'd270476;  7'd63: v = 19'd271524;
      7'd64: v = 19'd272557;
      default: v = 19'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tfidf_ram.sv =====
// tfidf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tfidf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/tfidf_mul.sv =====
// tfidf_mul: digit-serial multiplier, two multiplier bits per cycle, MSB first.
// Depends on tfidf_pkg.
`default_nettype none

module tfidf_mul (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [tfidf_pkg::LN_W-1:0]   multiplicand,
  input  logic [tfidf_pkg::CNT_W-1:0]  multiplier,
  output logic                         done,
  output logic [tfidf_pkg::PROD_W-1:0] product
);
  import tfidf_pkg::*;

  localparam int STEPS = CNT_W / 2;
  localparam int SW    = $clog2(STEPS + 1);
  localparam int M3_W  = LN_W + 2;

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SW-1:0]     step_r, step_nxt;
  logic [LN_W-1:0]   mcand_r;
  logic [M3_W-1:0]   mcand3_r;
  logic [CNT_W-1:0]  mplier_r;
  logic [PROD_W-1:0] acc_r;
  logic [PROD_W-1:0] addend;

  // pick 0, 1, 2 or 3 times the multiplicand for the top digit
  always_comb begin
    unique case (mplier_r[CNT_W-1 -: 2])
      2'd0:    addend = '0;
      2'd1:    addend = PROD_W'(mcand_r);
      2'd2:    addend = PROD_W'({mcand_r, 1'b0});
      default: addend = PROD_W'(mcand3_r);
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = SW'(STEPS);
    end else if (busy_r) begin
      step_nxt = step_r - SW'(1);
      if (step_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r  <= multiplicand;
      mcand3_r <= M3_W'(multiplicand) + M3_W'({multiplicand, 1'b0});
      mplier_r <= multiplier;
      acc_r    <= '0;
    end else if (busy_r) begin
      acc_r    <= (acc_r << 2) + addend;
      mplier_r <= mplier_r << 2;
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

`default_nettype wire

// ===== rtl/tfidf_div.sv =====
// tfidf_div: radix-4 restoring divider, two quotient bits per cycle, by an
// 8-bit nonzero divisor. Depends on tfidf_pkg.
`default_nettype none

module tfidf_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [tfidf_pkg::DIV_W-1:0]    dividend,
  input  logic [tfidf_pkg::NWORDS_W-1:0] divisor,
  output logic                           done,
  output logic [tfidf_pkg::DIV_W-1:0]    quotient
);
  import tfidf_pkg::*;

  localparam int STEPS = DIV_W / 2;
  localparam int SW    = $clog2(STEPS + 1);
  localparam int RW    = NWORDS_W + 1;

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [SW-1:0]       step_r, step_nxt;
  logic [DIV_W-1:0]    pq_r;
  logic [NWORDS_W-1:0] rem_r;
  logic [NWORDS_W-1:0] dv_r;
  logic [RW-1:0]       r_hi, r_lo, dv_ext;
  logic [NWORDS_W-1:0] rem_hi, rem_lo;
  logic                q_hi, q_lo;

  // two dependent restoring steps on a 9-bit partial remainder
  always_comb begin
    dv_ext = RW'(dv_r);
    r_hi   = {rem_r, pq_r[DIV_W-1]};
    q_hi   = (r_hi >= dv_ext);
    rem_hi = q_hi ? NWORDS_W'(r_hi - dv_ext) : NWORDS_W'(r_hi);
    r_lo   = {rem_hi, pq_r[DIV_W-2]};
    q_lo   = (r_lo >= dv_ext);
    rem_lo = q_lo ? NWORDS_W'(r_lo - dv_ext) : NWORDS_W'(r_lo);
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = SW'(STEPS);
    end else if (busy_r) begin
      step_nxt = step_r - SW'(1);
      if (step_r == SW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
  end

  // dividend bits shift out the top while quotient bits shift in below
  always_ff @(posedge clk) begin
    if (start) begin
      pq_r  <= dividend;
      rem_r <= '0;
      dv_r  <= divisor;
    end else if (busy_r) begin
      pq_r  <= {pq_r[DIV_W-3:0], q_hi, q_lo};
      rem_r <= rem_lo;
    end
  end

  assign done     = done_r;
  assign quotient = pq_r;

endmodule

`default_nettype wire

// ===== rtl/tf_idf_scorer.sv =====
// tf_idf_scorer: top level. Keeps per-word document frequencies in a RAM and
// scores words as count * ln(N/df) / num_words in unsigned Q18.16.
// Depends on tfidf_pkg, tfidf_ram, tfidf_mul and tfidf_div.
//
//   Channel  Ports                          Word / access
//   -------  -----------------------------  ----------------------------------
//   input    in_valid, in_ready, in_data    kind, word_index, count
//   result   out_valid, out_ready, out_data score, idf_undefined (scores only)
//   config   cfg_we, cfg_index, cfg_wdata   0 num_docs, 1 num_words; no wait
//
// Steps from one accepted word to the earliest next one: a clear word is written
// as it is accepted; a tally word takes a RAM read, then read-modify-write. A
// score word takes the log lookup on the RAM data, the 2-bit digit-serial
// multiplier, the radix-4 divider, the load of the output register and the
// return to idle. A score with zero df or a log of zero or less skips both units.
// Reset: synchronous, active low. After reset a clearing pass zeroes the
// frequency RAM, one entry a cycle, min(MAX_VOCAB, 128) entries; no input word
// is taken meanwhile, configuration writes are.
// Stalls: a finished score waits in the output register; the next input word
// is taken while it waits. A second score holds at its end until the output
// register frees.
`default_nettype none

module tf_idf_scorer #(
  parameter int MAX_DOCS  = 16,
  parameter int MAX_VOCAB = 128
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  tfidf_pkg::tfidf_in_t             in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output tfidf_pkg::tfidf_out_t            out_data,
  input  logic                             cfg_we,
  input  logic [tfidf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfidf_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tfidf_pkg::*;

  // table covers at most 64 documents; word_index reaches at most 128 words
  localparam int DOC_CAP = (MAX_DOCS < LN_MAX_IDX) ? MAX_DOCS : LN_MAX_IDX;
  localparam int DF_W    = $clog2(DOC_CAP + 1);
  localparam int VOC_D   = (MAX_VOCAB < WORD_SPAN) ? MAX_VOCAB : WORD_SPAN;
  localparam int AW      = (VOC_D > 1) ? $clog2(VOC_D) : 1;
  localparam int WRAP_W  = 2 * WORD_W;

  localparam logic [LN_IDX_W-1:0] DOC_CAP_L  = LN_IDX_W'(DOC_CAP);
  localparam logic [AW-1:0]       LAST_ENTRY = AW'(VOC_D - 1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_TALLY = 7'b0000100,
    ST_LOOK  = 7'b0001000,
    ST_MUL   = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_HOLD  = 7'b1000000
  } state_t;

  // word_index modulo the vocabulary: seven conditional subtracts
  function automatic logic [WORD_W-1:0] wrap_word(input logic [WORD_W-1:0] w);
    logic [WRAP_W-1:0] r;
    r = WRAP_W'(w);
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (r >= (WRAP_W'(VOC_D) << k)) begin
        r = r - (WRAP_W'(VOC_D) << k);
      end
    end
    return r[WORD_W-1:0];
  endfunction

  state_t              state_r, state_nxt;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [DOCS_W-1:0]   num_docs_r;
  logic [NWORDS_W-1:0] num_words_r;
  logic [AW-1:0]       w_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [SCORE_W-1:0]  res_score_r;
  logic                res_undef_r;
  logic                out_valid_r, out_valid_nxt;
  tfidf_out_t          out_data_r;

  logic                in_fire, out_fire, out_load;
  logic [AW-1:0]       in_word;
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [DF_W-1:0]     ram_wdata, ram_rdata;
  logic [LN_IDX_W-1:0] eff_n, nd_ext, df_ext;
  logic [LN_W-1:0]     ln_num, ln_den, ln_diff;
  logic                df_zero, idf_pos, tally_inc;
  logic [NWORDS_W-1:0] divisor;
  logic                mul_start, mul_done, div_start, div_done;
  logic [PROD_W-1:0]   mul_prod;
  logic [DIV_W-1:0]    div_quot;
  logic [SCORE_W-1:0]  score_sat;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_word  = AW'(wrap_word(in_data.word_index));
  assign out_fire = out_valid_r && out_ready;
  assign out_load = (state_r == ST_HOLD) && (!out_valid_r || out_ready);

  // effective document count: zero acts as one, clamp to DOC_CAP (MAX_DOCS, at most the table size)
  assign nd_ext = LN_IDX_W'(num_docs_r);
  always_comb begin
    priority if (nd_ext == '0) begin
      eff_n = LN_IDX_W'(1);
    end else if (nd_ext > DOC_CAP_L) begin
      eff_n = DOC_CAP_L;
    end else begin
      eff_n = nd_ext;
    end
  end

  // df from the RAM is valid in the cycle after acceptance
  assign df_ext    = LN_IDX_W'(ram_rdata);
  assign df_zero   = (ram_rdata == '0);
  assign ln_num    = ln_q16(eff_n);
  assign ln_den    = ln_q16(df_ext);
  assign ln_diff   = ln_num - ln_den;
  assign idf_pos   = !df_zero && (ln_num > ln_den);
  assign tally_inc = (cnt_r != '0) && (df_ext < eff_n);
  assign divisor   = (num_words_r == '0) ? NWORDS_W'(1) : num_words_r;

  assign mul_start = (state_r == ST_LOOK) && idf_pos;
  assign div_start = (state_r == ST_MUL) && mul_done;
  assign score_sat = (|div_quot[DIV_W-1:SCORE_W]) ? '1 : div_quot[SCORE_W-1:0];

  // RAM write: clearing sweep, clear word, or tally read-modify-write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_r;
    ram_wdata = '0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
      end
      ST_IDLE: begin
        ram_we    = in_fire && (in_data.kind == KIND_CLEAR);
        ram_waddr = in_word;
      end
      ST_TALLY: begin
        ram_we    = tally_inc;
        ram_wdata = ram_rdata + DF_W'(1);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  tfidf_ram #(
    .WIDTH (DF_W),
    .DEPTH (VOC_D)
  ) u_df_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (in_word),
    .rdata (ram_rdata)
  );

  tfidf_mul u_mul (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (mul_start),
    .multiplicand (ln_diff),
    .multiplier   (cnt_r),
    .done         (mul_done),
    .product      (mul_prod)
  );

  tfidf_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIV_W'(mul_prod)),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_ENTRY) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_data.kind)
            KIND_TALLY: state_nxt = ST_TALLY;
            KIND_SCORE: state_nxt = ST_LOOK;
            default:    state_nxt = ST_IDLE;  // clear is done now; drop kind 3
          endcase
        end
      end
      ST_TALLY: state_nxt = ST_IDLE;
      ST_LOOK:  state_nxt = idf_pos ? ST_MUL : ST_HOLD;
      ST_MUL: begin
        if (mul_done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      num_docs_r  <= NUM_DOCS_RST;
      num_words_r <= NUM_WORDS_RST;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      // drop writes to unmapped register slots
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_NUM_DOCS: begin
            num_docs_r <= cfg_wdata[DOCS_W-1:0];
          end
          CFG_NUM_WORDS: begin
            num_words_r <= cfg_wdata[NWORDS_W-1:0];
          end
          default: ;
        endcase
      end
    end
  end

  // payload: hold the accepted word, build the result, load the output
  always_ff @(posedge clk) begin
    if (in_fire) begin
      w_r   <= in_word;
      cnt_r <= in_data.count;
    end
    if (state_r == ST_LOOK) begin
      res_undef_r <= df_zero;
      res_score_r <= '0;
    end else if ((state_r == ST_DIV) && div_done) begin
      res_score_r <= score_sat;
    end
    if (out_load) begin
      out_data_r.score         <= res_score_r;
      out_data_r.idf_undefined <= res_undef_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == ST_MUL))
    else $error("multiplier finished outside the multiply state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == ST_DIV))
    else $error("divider finished outside the divide state");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.idf_undefined) |-> (out_data_r.score == '0))
    else $error("undefined idf with nonzero score");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("result load lost");

endmodule

`default_nettype wire
